@@ src/base64_url_variant_encoder_assert.svh @@
// Assertion macros for the encoder RTL.
`ifndef BASE64_URL_VARIANT_ENCODER_ASSERT_SVH
`define BASE64_URL_VARIANT_ENCODER_ASSERT_SVH

// Checked property, switched off while reset is active.
`define B64U_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define B64U_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/b64u_pkg.sv @@
// Types, constants and the character table of the Base64 encoder.
`default_nettype none

package b64u_pkg;

	// Pad character '_'.
	localparam logic [7:0] PAD_CHAR = 8'h5F;

	// Number of character slots a single input item can produce.
	localparam int unsigned JOB_SLOTS = 4;

	// One classified input item: up to four sextets or pads to emit.
	typedef struct packed {
		logic [JOB_SLOTS-1:0][5:0] sextet;
		logic [JOB_SLOTS-1:0]      pad;
		logic [1:0]                last_idx;
		logic                      last;
	} job_t;

	// Maps a six-bit group to its ASCII character.
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] ext;
		ext = {2'b00, v};
		if (v < 6'd26) begin
			return ext + 8'd65;
		end else if (v < 6'd52) begin
			return ext + 8'd71;
		end else if (v < 6'd62) begin
			return ext - 8'd4;
		end else if (v == 6'd62) begin
			return 8'h2D;
		end else begin
			return 8'h7E;
		end
	endfunction

endpackage

`default_nettype wire

@@ src/b64u_front.sv @@
// Front end: tracks the group position and splits each byte into sextets and pads.
`default_nettype none

module b64u_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             pad_enable,
	output b64u_pkg::job_t        job
);

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	logic [1:0] phase_q;
	logic [3:0] held_q;
	logic [1:0] phase_next;
	logic [3:0] held_next;

	// Build the job for the byte and the state it leaves behind.
	always_comb begin
		job = '0;
		job.last = last_byte;
		phase_next = PHASE_SECOND;
		held_next = {2'b00, data_byte[1:0]};
		unique case (phase_q)
			PHASE_SECOND: begin
				job.sextet[0] = {held_q[1:0], data_byte[7:4]};
				job.sextet[1] = {data_byte[3:0], 2'b00};
				job.pad[2] = 1'b1;
				job.last_idx = (last_byte && pad_enable) ? 2'd2 :
					(last_byte ? 2'd1 : 2'd0);
				phase_next = PHASE_THIRD;
				held_next = data_byte[3:0];
			end
			PHASE_THIRD: begin
				job.sextet[0] = {held_q, data_byte[7:6]};
				job.sextet[1] = data_byte[5:0];
				job.last_idx = 2'd1;
				phase_next = PHASE_FIRST;
				held_next = 4'd0;
			end
			default: begin
				// The first phase; the unused code behaves the same way.
				job.sextet[0] = data_byte[7:2];
				job.sextet[1] = {data_byte[1:0], 4'b0000};
				job.pad[2] = 1'b1;
				job.pad[3] = 1'b1;
				job.last_idx = (last_byte && pad_enable) ? 2'd3 :
					(last_byte ? 2'd1 : 2'd0);
			end
		endcase
		// The last byte of a message closes the group.
		if (last_byte) begin
			phase_next = PHASE_FIRST;
			held_next = 4'd0;
		end
	end

	// Group position and leftover bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			held_q <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_next;
			held_q <= held_next;
		end
	end

endmodule

`default_nettype wire

@@ src/b64u_fifo.sv @@
// Job queue between the front end and the character emitter.
`default_nettype none

module b64u_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64u_pkg::job_t   wr_job,
	output logic                  full,
	input  wire logic             pop,
	output b64u_pkg::job_t        rd_job,
	output logic                  empty
);

`include "base64_url_variant_encoder_assert.svh"

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64u_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The count never passes the depth and follows pushes and pops.
	`B64U_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`B64U_ASSERT(a_count_up, clk, arst_n, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1), "count did not rise on push")
	`B64U_ASSERT(a_count_down, clk, arst_n, (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1), "count did not fall on pop")

endmodule

`default_nettype wire

@@ src/b64u_back.sv @@
// Back end: walks each job one character at a time into the output register.
`default_nettype none

module b64u_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire b64u_pkg::job_t   job,
	input  wire logic             job_empty,
	output logic                  job_pop,
	output logic [7:0]            out_char,
	output logic                  last_char,
	output logic                  empty,
	input  wire logic             pop
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic       at_end;
	logic [7:0] next_char;

	// Character at the current slot of the head job.
	assign at_end = (idx_q == job.last_idx);
	assign next_char = job.pad[idx_q] ? b64u_pkg::PAD_CHAR :
		b64u_pkg::sextet_char(job.sextet[idx_q]);
	assign load = (!valid_q || pop) && !job_empty;
	assign job_pop = load && at_end;

	// Slot counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= job.last && at_end;
		end
	end

	assign out_char = char_q;
	assign last_char = last_q;
	assign empty = !valid_q;

endmodule

`default_nettype wire

@@ src/base64_url_variant_encoder.sv @@
// Streaming Base64 encoder with the '-' '~' alphabet and '_' padding.
// Input channel: push with data_byte and last_byte; an item is taken at a clock
// edge where push is high and full is low. Each byte is split at once into a
// job of one to four characters that enters a queue of QUEUE_DEPTH jobs.
// Output channel: while empty is low, out_char and last_char show the oldest
// character; it is taken at an edge where pop is high. last_char marks the end
// of an encoded message, after any pads.
// Each byte's job is stored in the queue, and its characters then pass through the output register.
// Throughput: one character per cycle while pop is high, set by the single output
// register; an item yields one to four characters (4/3 on average).
// When the receiver stalls, the output register holds and the queue fills; full
// rises once QUEUE_DEPTH jobs wait.
// Reset clears the group position, the queue and the output, and sets
// pad_enable to 1. pad_enable lies at byte address 0 of the APB port; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module base64_url_variant_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_char,
	output logic             last_char
);

	localparam logic REG_PAD_ENABLE = 1'b0;

	logic           pad_enable_q;
	logic           accept;
	logic           job_pop;
	logic           job_empty;
	b64u_pkg::job_t front_job;
	b64u_pkg::job_t head_job;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PAD_ENABLE)) begin
			pad_enable_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_PAD_ENABLE) ? {31'd0, pad_enable_q} : 32'd0;

	assign accept = push && !full;

	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.pad_enable (pad_enable_q),
		.job        (front_job)
	);

	b64u_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.full   (full),
		.pop    (job_pop),
		.rd_job (head_job),
		.empty  (job_empty)
	);

	b64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.out_char  (out_char),
		.last_char (last_char),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the streaming Base64 encoder with '-' '~' alphabet and '_' pads.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 4;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_STRETCH = 100;
	localparam int STALL_CYCLES = 250;

	// Register addresses; the second one lies beyond the register list.
	localparam logic [2:0] PAD_ENABLE_ADDR = 3'd0;
	localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

	// Character table, first character in the top byte.
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-~";

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} enc_char_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed stimulus; want_len of zero leaves the expectation to the predictor.
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [7:0]  value;
		logic        last;
		logic [31:0] want;
		logic [2:0]  want_len;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] out_char;
	logic last_char;

	// Encoder state as the predictor sees it.
	logic [1:0] group_pos;
	logic [3:0] leftover;
	logic pad_on;

	enc_char_t expected_chars[$];
	enc_char_t predicted[$];
	stim_row_t directed_rows[$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	int stretch_items;

	base64_url_variant_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.out_char(out_char),
		.last_char(last_char)
	);

	always #CLK_HALF clk = ~clk;

	// Predicts the characters one byte produces and advances the group position.
	function automatic void encode_byte(input logic [7:0] b, input logic last);
		logic [5:0] sx[$];
		int n_pads;
		n_pads = 0;
		predicted.delete();
		case (group_pos)
			2'd1: begin
				sx.push_back({leftover[1:0], b[7:4]});
				leftover = b[3:0];
				group_pos = 2'd2;
			end
			2'd2: begin
				sx.push_back({leftover, b[7:6]});
				sx.push_back(b[5:0]);
				leftover = '0;
				group_pos = 2'd0;
			end
			default: begin
				sx.push_back(b[7:2]);
				leftover = {2'b00, b[1:0]};
				group_pos = 2'd1;
			end
		endcase
		// The final byte flushes a partial group and adds pads when enabled.
		if (last) begin
			if (group_pos == 2'd1) begin
				sx.push_back({leftover[1:0], 4'b0000});
				n_pads = pad_on ? 2 : 0;
			end else if (group_pos == 2'd2) begin
				sx.push_back({leftover, 2'b00});
				n_pads = pad_on ? 1 : 0;
			end
			group_pos = 2'd0;
			leftover = '0;
		end
		foreach (sx[i])
			predicted.push_back('{code: ALPHABET[8*(63 - sx[i]) +: 8], last: 1'b0});
		for (int i = 0; i < n_pads; i++)
			predicted.push_back('{code: b64u_pkg::PAD_CHAR, last: 1'b0});
		if (last)
			predicted[predicted.size() - 1].last = 1'b1;
	endfunction

	// Byte source that favors the all-zero and all-one patterns now and then.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Offers one item and records what it should produce once it is taken.
	task automatic send_item(input logic [7:0] b, input logic last, input logic [31:0] want,
			input int want_len);
		push <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		encode_byte(b, last);
		if (want_len > 0) begin
			for (int i = 0; i < want_len; i++)
				expected_chars.push_back('{code: want[8*(want_len - 1 - i) +: 8],
					last: last && (i == want_len - 1)});
		end else begin
			foreach (predicted[i])
				expected_chars.push_back(predicted[i]);
		end
		stretch_items++;
		@(negedge clk);
	endtask

	// Random gaps on the input side.
	task automatic idle_sender();
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Holds the input until every expected character has been taken.
	task automatic drain();
		push <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write followed by a read back of pad_enable.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == PAD_ENABLE_ADDR)
			pad_on = value[0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PAD_ENABLE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {31'b0, pad_on}) begin
			$display("%0t ns: ERROR pad_enable read back expected %h, got %h",
				$time, {31'b0, pad_on}, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sends one complete message of random bytes.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			idle_sender();
			send_item(pick_byte(), i == len - 1, '0, 0);
		end
	endtask

	task automatic add_row(input row_kind_t kind, input logic [2:0] addr, input logic [7:0] value,
			input logic last, input logic [31:0] want, input logic [2:0] want_len);
		directed_rows.push_back('{kind: kind, addr: addr, value: value, last: last,
			want: want, want_len: want_len});
	endtask

	// Receiver: long hold-off on request, otherwise random stalls.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every character taken is compared with the oldest expectation.
	always @(posedge clk) begin : check_output
		enc_char_t exp_c;
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				$display("%0t ns: ERROR character with none expected: expected nothing, got %h/%b",
					$time, out_char, last_char);
				errors++;
			end else begin
				exp_c = expected_chars.pop_front();
				if (out_char !== exp_c.code) begin
					$display("%0t ns: ERROR out_char expected %h, got %h",
						$time, exp_c.code, out_char);
					errors++;
				end
				if (last_char !== exp_c.last) begin
					$display("%0t ns: ERROR last_char expected %b, got %b",
						$time, exp_c.last, last_char);
					errors++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: ERROR timeout with %0d characters outstanding",
				$time, expected_chars.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		group_pos = '0;
		leftover = '0;
		pad_on = 1'b1;

		// Directed rows: extremes, both flush lengths, pads on and off, unmapped register.
		add_row(ROW_ITEM, '0, 8'h00, 1'b1, "AA__", 3'd4);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b1, "~w__", 3'd4);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b0, "~", 3'd1);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b1, "~8_", 3'd3);
		add_row(ROW_ITEM, '0, 8'h00, 1'b0, "A", 3'd1);
		add_row(ROW_ITEM, '0, 8'h00, 1'b0, "A", 3'd1);
		add_row(ROW_ITEM, '0, 8'h00, 1'b1, "AA", 3'd2);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b0, "~", 3'd1);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b0, "~", 3'd1);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b1, "~~", 3'd2);
		add_row(ROW_ITEM, '0, 8'hFB, 1'b0, "-", 3'd1);
		add_row(ROW_ITEM, '0, 8'hFF, 1'b0, "~", 3'd1);
		add_row(ROW_ITEM, '0, 8'hBF, 1'b1, "-~", 3'd2);
		add_row(ROW_ITEM, '0, 8'hAA, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'h55, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'hAA, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'h55, 1'b1, '0, 3'd0);
		add_row(ROW_CFG, PAD_ENABLE_ADDR, 8'h00, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'h00, 1'b1, "AA", 3'd2);
		add_row(ROW_ITEM, '0, 8'h80, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'h01, 1'b1, '0, 3'd0);
		add_row(ROW_CFG, UNMAPPED_ADDR, 8'h01, 1'b0, '0, 3'd0);
		add_row(ROW_ITEM, '0, 8'h7F, 1'b1, '0, 3'd0);
		add_row(ROW_CFG, PAD_ENABLE_ADDR, 8'h01, 1'b0, '0, 3'd0);

		// Reset once at the start.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 88;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[i].addr, {24'b0, directed_rows[i].value});
			end else begin
				idle_sender();
				send_item(directed_rows[i].value, directed_rows[i].last,
					directed_rows[i].want, int'(directed_rows[i].want_len));
			end
		end

		// Three random stretches with different idle patterns and pad settings.
		for (int s = 0; s < 3; s++) begin
			drain();
			case (s)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(PAD_ENABLE_ADDR, (s == 1) ? 32'd0 : 32'd1);
			stretch_items = 0;
			// With no idling, hold the output back so the input side backs up.
			if (s == 2) begin
				stall_left = STALL_CYCLES;
				send_message(30);
				drain();
			end
			while (stretch_items < ITEMS_PER_STRETCH)
				send_message(($urandom_range(4) == 0) ? $urandom_range(7, 24) :
					$urandom_range(1, 6));
		end

		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_fifo.sv
src/b64u_back.sv
src/base64_url_variant_encoder.sv
bench/testbench.sv
